[hw/rtl/cursor_linked_list_engine_core_defines.svh]
// ----------------------------------------------------------------------------
// cursor linked list engine assertion macros
// concurrent checks on aclk, held off while aresetn is low
// ----------------------------------------------------------------------------
`ifndef CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH
`define CURSOR_LINKED_LIST_ENGINE_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define CLLE_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error("clle assertion failed");
`define CLLE_NEVER(lbl, cond) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) !(cond)) \
        else $error("clle forbidden condition seen");
`else
`define CLLE_ASSERT(lbl, prop)
`define CLLE_NEVER(lbl, cond)
`endif

`endif

[hw/rtl/clle_pkg.sv]
// ----------------------------------------------------------------------------
// clle_pkg
// shared types and constants of the cursor linked list engine
// ----------------------------------------------------------------------------
`default_nettype none

package clle_pkg;

    localparam int CLLE_CAPACITY   = 64;
    localparam int CLLE_DATA_WIDTH = 32;

    // port field widths
    localparam int REQ_W    = 3;
    localparam int POS_W    = 7;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;
    localparam int IN_W     = 40;
    localparam int OUT_W    = 56;

    // fixed store entries
    localparam int LIST_HEAD = 0;
    localparam int FREE_HEAD = 1;

    typedef enum logic [REQ_W-1:0] {
        REQ_INSERT   = 3'd0,
        REQ_APPEND   = 3'd1,
        REQ_REMOVE   = 3'd2,
        REQ_REPLACE  = 3'd3,
        REQ_RETRIEVE = 3'd4,
        REQ_SEARCH   = 3'd5
    } req_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_OK         = 2'd0,
        STAT_ERROR      = 2'd1,
        STAT_INFEASIBLE = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_WALK,
        S_ALLOC_FREE,
        S_ALLOC_NODE,
        S_ALLOC_LINK,
        S_ALLOC_PRED,
        S_REM_UNLINK,
        S_REM_FREE,
        S_REM_HEAD,
        S_RETRIEVE,
        S_SRCH_HEAD,
        S_SRCH_CMP,
        S_RESP
    } state_t;

endpackage

`default_nettype wire

[hw/rtl/clle_ram.sv]
// ----------------------------------------------------------------------------
// clle_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module clle_ram #(
    parameter int DEPTH = 66,
    parameter int WIDTH = 32
) (
    input  wire logic                     aclk,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

[hw/rtl/cursor_linked_list_engine_core.sv]
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core
// positional list kept as a cursor linked list with a free chain
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request word: opcode on s_tuser, position and
//   value on s_tdata. m_ channel returns one result word per request with
//   status, data read, search position, element count and full/empty flags.
//   links and node values live in two memories with registered reads; a
//   request walks the link chain one entry per cycle to the entry before its
//   position (append walks to the list end). insert/append then take a node
//   off the free chain, remove puts one back, replace and retrieve act on the
//   node reached, search compares node by node until a match or the list end;
//   rejected or unknown opcodes go straight to the result.
//   after reset the link memory is filled in one pass over all CAPACITY + 2
//   entries (free chain ascending, list empty); s_tready stays low until it ends.
//   one request is in work at a time; the result sits in an output register,
//   so a stalled m_tready holds only the next result, not the next accept.
// ----------------------------------------------------------------------------
`default_nettype none
`include "cursor_linked_list_engine_core_defines.svh"

module cursor_linked_list_engine_core
    import clle_pkg::*;
#(
    parameter int CAPACITY   = CLLE_CAPACITY,
    parameter int DATA_WIDTH = CLLE_DATA_WIDTH
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,   // position[6:0], value[38:7], zero pad
    input  wire logic [REQ_W-1:0] s_tuser,   // req_type[2:0]
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    output logic      [OUT_W-1:0] m_tdata    // status[1:0], data_out[33:2],
                                             // found_position[40:34], count[47:41],
                                             // is_full[48], is_empty[49], zero pad
);

    localparam int STORE = CAPACITY + 2;
    localparam int AW    = $clog2(STORE);
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int MW    = ((AW > POS_W) ? AW : POS_W) + 1;

    localparam logic [AW-1:0] NIL_A  = AW'(LIST_HEAD);
    localparam logic [AW-1:0] FREE_A = AW'(FREE_HEAD);
    localparam logic [AW-1:0] LAST_A = AW'(STORE - 1);

    state_t                state_reg, state_next;
    logic [AW-1:0]         init_reg, init_next;
    logic [REQ_W-1:0]      req_reg, req_next;
    logic [POS_W-1:0]      pos_reg, pos_next;
    logic [DATA_WIDTH-1:0] val_reg, val_next;
    logic [AW-1:0]         p_reg, p_next;
    logic [AW-1:0]         node_reg, node_next;
    logic [AW-1:0]         succ_reg, succ_next;
    logic [AW-1:0]         steps_reg, steps_next;
    logic [AW-1:0]         j_reg, j_next;
    logic [CW-1:0]         count_reg, count_next;
    status_t               status_reg, status_next;
    logic [DATA_WIDTH-1:0] data_reg, data_next;
    logic [AW-1:0]         found_reg, found_next;
    logic                  m_valid_reg, m_valid_next;
    logic [OUT_W-1:0]      m_data_reg, m_data_next;

    logic [AW-1:0]         lnk_rd_addr, lnk_rd_data, lnk_wr_addr, lnk_wr_data;
    logic                  lnk_we;
    logic [AW-1:0]         val_rd_addr, val_wr_addr;
    logic [DATA_WIDTH-1:0] val_rd_data, val_wr_data;
    logic                  val_we;

    logic [POS_W-1:0]      in_pos;
    logic [VALUE_W-1:0]    in_value;
    logic [63:0]           in_value_wide;
    logic [63:0]           data_wide;
    logic [MW-1:0]         cnt_ext, cap_ext;
    logic [AW-1:0]         cand_p, cand_j;
    logic                  cand_go;

    clle_ram #(.DEPTH(STORE), .WIDTH(AW)) u_link_ram (
        .aclk    (aclk),
        .rd_addr (lnk_rd_addr),
        .rd_data (lnk_rd_data),
        .wr_en   (lnk_we),
        .wr_addr (lnk_wr_addr),
        .wr_data (lnk_wr_data)
    );

    clle_ram #(.DEPTH(STORE), .WIDTH(DATA_WIDTH)) u_value_ram (
        .aclk    (aclk),
        .rd_addr (val_rd_addr),
        .rd_data (val_rd_data),
        .wr_en   (val_we),
        .wr_addr (val_wr_addr),
        .wr_data (val_wr_data)
    );

    assign in_pos        = s_tdata[POS_W-1:0];
    assign in_value      = s_tdata[POS_W+VALUE_W-1:POS_W];
    assign in_value_wide = 64'(in_value);
    assign data_wide     = 64'(data_reg);
    assign cnt_ext       = MW'(count_reg);
    assign cap_ext       = MW'(CAPACITY);

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_INIT;
            init_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            init_reg    <= init_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        req_reg    <= req_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        p_reg      <= p_next;
        node_reg   <= node_next;
        succ_reg   <= succ_next;
        steps_reg  <= steps_next;
        j_reg      <= j_next;
        status_reg <= status_next;
        data_reg   <= data_next;
        found_reg  <= found_next;
        m_data_reg <= m_data_next;
    end

    // request latch at accept
    always_comb begin
        if (state_reg == S_IDLE && s_tvalid) begin
            req_next = s_tuser;
            pos_next = in_pos;
            val_next = in_value_wide[DATA_WIDTH-1:0];
        end else begin
            req_next = req_reg;
            pos_next = pos_reg;
            val_next = val_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        init_next    = init_reg;
        p_next       = p_reg;
        node_next    = node_reg;
        succ_next    = succ_reg;
        steps_next   = steps_reg;
        j_next       = j_reg;
        count_next   = count_reg;
        status_next  = status_reg;
        data_next    = data_reg;
        found_next   = found_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        lnk_rd_addr  = NIL_A;
        lnk_we       = 1'b0;
        lnk_wr_addr  = NIL_A;
        lnk_wr_data  = NIL_A;
        val_rd_addr  = NIL_A;
        val_we       = 1'b0;
        val_wr_addr  = NIL_A;
        val_wr_data  = val_reg;
        cand_p       = lnk_rd_data;
        cand_j       = AW'(1);
        cand_go      = 1'b0;

        case (state_reg)
            S_INIT: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = init_reg;
                lnk_wr_data = (init_reg == NIL_A || init_reg == LAST_A) ? NIL_A
                                                                       : init_reg + 1'b1;
                if (init_reg == LAST_A) begin
                    state_next = S_IDLE;
                end else begin
                    init_next = init_reg + 1'b1;
                end
            end

            S_IDLE: begin
                if (s_tvalid) begin
                    p_next      = NIL_A;
                    data_next   = '0;
                    found_next  = '0;
                    status_next = STAT_OK;
                    state_next  = S_WALK;
                    steps_next  = AW'(MW'(in_pos) - 1'b1);
                    case (req_t'(s_tuser))
                        REQ_INSERT: begin
                            if (in_pos == '0 || MW'(in_pos) > cap_ext) begin
                                status_next = STAT_INFEASIBLE;
                                state_next  = S_RESP;
                            end else if (cnt_ext >= cap_ext ||
                                         MW'(in_pos) > cnt_ext + 1'b1) begin
                                status_next = STAT_ERROR;
                                state_next  = S_RESP;
                            end
                        end
                        REQ_APPEND: begin
                            steps_next = AW'(count_reg);
                            if (cnt_ext >= cap_ext) begin
                                status_next = STAT_ERROR;
                                state_next  = S_RESP;
                            end
                        end
                        REQ_REMOVE: begin
                            if (count_reg == '0) begin
                                status_next = STAT_INFEASIBLE;
                                state_next  = S_RESP;
                            end else if (in_pos == '0 || MW'(in_pos) > cnt_ext) begin
                                status_next = STAT_ERROR;
                                state_next  = S_RESP;
                            end
                        end
                        REQ_REPLACE, REQ_RETRIEVE: begin
                            if (in_pos == '0 || MW'(in_pos) > cnt_ext) begin
                                status_next = STAT_ERROR;
                                state_next  = S_RESP;
                            end
                        end
                        REQ_SEARCH: begin
                            state_next = S_SRCH_HEAD;
                        end
                        default: begin
                            status_next = STAT_INFEASIBLE;
                            state_next  = S_RESP;
                        end
                    endcase
                end
            end

            // link read data is next_link[p_reg]
            S_WALK: begin
                if (steps_reg != '0) begin
                    p_next      = lnk_rd_data;
                    lnk_rd_addr = lnk_rd_data;
                    steps_next  = steps_reg - 1'b1;
                end else begin
                    case (req_t'(req_reg))
                        REQ_INSERT, REQ_APPEND: begin
                            succ_next   = lnk_rd_data;
                            lnk_rd_addr = FREE_A;
                            state_next  = S_ALLOC_FREE;
                        end
                        REQ_REMOVE: begin
                            node_next   = lnk_rd_data;
                            lnk_rd_addr = lnk_rd_data;
                            val_rd_addr = lnk_rd_data;
                            state_next  = S_REM_UNLINK;
                        end
                        REQ_REPLACE: begin
                            val_we      = 1'b1;
                            val_wr_addr = lnk_rd_data;
                            state_next  = S_RESP;
                        end
                        REQ_RETRIEVE: begin
                            val_rd_addr = lnk_rd_data;
                            state_next  = S_RETRIEVE;
                        end
                        default: begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            S_ALLOC_FREE: begin
                node_next   = lnk_rd_data;
                lnk_rd_addr = lnk_rd_data;
                state_next  = S_ALLOC_NODE;
            end

            S_ALLOC_NODE: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = FREE_A;
                lnk_wr_data = lnk_rd_data;
                val_we      = 1'b1;
                val_wr_addr = node_reg;
                state_next  = S_ALLOC_LINK;
            end

            S_ALLOC_LINK: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = node_reg;
                lnk_wr_data = succ_reg;
                state_next  = S_ALLOC_PRED;
            end

            S_ALLOC_PRED: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = p_reg;
                lnk_wr_data = node_reg;
                count_next  = count_reg + 1'b1;
                state_next  = S_RESP;
            end

            // unlink node from its predecessor, fetch free head
            S_REM_UNLINK: begin
                data_next   = val_rd_data;
                lnk_we      = 1'b1;
                lnk_wr_addr = p_reg;
                lnk_wr_data = lnk_rd_data;
                lnk_rd_addr = FREE_A;
                state_next  = S_REM_FREE;
            end

            S_REM_FREE: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = node_reg;
                lnk_wr_data = lnk_rd_data;
                state_next  = S_REM_HEAD;
            end

            S_REM_HEAD: begin
                lnk_we      = 1'b1;
                lnk_wr_addr = FREE_A;
                lnk_wr_data = node_reg;
                count_next  = count_reg - 1'b1;
                state_next  = S_RESP;
            end

            S_RETRIEVE: begin
                data_next  = val_rd_data;
                state_next = S_RESP;
            end

            S_SRCH_HEAD: begin
                cand_go = 1'b1;
            end

            S_SRCH_CMP: begin
                if (val_rd_data == val_reg) begin
                    found_next = j_reg;
                    state_next = S_RESP;
                end else begin
                    cand_j  = j_reg + 1'b1;
                    cand_go = 1'b1;
                end
            end

            S_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = OUT_W'({
                        count_reg == '0,
                        count_reg == CW'(CAPACITY),
                        POS_W'(count_reg),
                        POS_W'(found_reg),
                        data_wide[VALUE_W-1:0],
                        status_reg
                    });
                    state_next   = S_IDLE;
                end
            end

            default: begin
                state_next = S_IDLE;
            end
        endcase

        // next search candidate: stop at chain end or past the count
        if (cand_go) begin
            if (cand_j > AW'(count_reg) || cand_p == NIL_A) begin
                status_next = STAT_ERROR;
                found_next  = '0;
                state_next  = S_RESP;
            end else begin
                p_next      = cand_p;
                j_next      = cand_j;
                lnk_rd_addr = cand_p;
                val_rd_addr = cand_p;
                state_next  = S_SRCH_CMP;
            end
        end
    end

    `CLLE_NEVER(a_count_range, count_reg > CW'(CAPACITY))
    `CLLE_ASSERT(a_accept_leaves_idle, s_tvalid && s_tready |=> state_reg != S_IDLE)
    `CLLE_ASSERT(a_count_hold, (state_reg != S_ALLOC_PRED && state_reg != S_REM_HEAD) |=> $stable(count_reg))
    `CLLE_NEVER(a_search_nil, state_reg == S_SRCH_CMP && p_reg == NIL_A)

endmodule

`default_nettype wire

[tb/cursor_linked_list_engine_core_tb.sv]
// ----------------------------------------------------------------------------
// cursor_linked_list_engine_core_tb
// drives list requests into the engine and checks every result word against
// a positional list kept in the bench; covers empty, full and out-of-range
// cases, duplicates for search, random pacing on both channels and a long
// result stall that backs up the request channel
// ----------------------------------------------------------------------------
`default_nettype none

module cursor_linked_list_engine_core_tb;
    import clle_pkg::*;

    localparam int CAPACITY      = CLLE_CAPACITY;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int HOLD_CYCLES   = 400;
    localparam int DRAIN_CYCLES  = 100;
    localparam int MAX_POSITION  = 127;

    localparam logic [REQ_W-1:0] REQ_UNUSED_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_UNUSED_HI = 3'd7;

    typedef enum int {FILL_HEAVY, DRAIN_HEAVY, BALANCED} mix_t;

    typedef struct {
        status_t     status;
        logic [31:0] data_out;
        logic [6:0]  found_position;
        logic [6:0]  count;
        logic        is_full;
        logic        is_empty;
    } reply_t;

    logic             aclk = 1'b0;
    logic             aresetn;
    logic             s_tvalid;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata;
    logic [REQ_W-1:0] s_tuser;
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;

    logic [31:0] list_words[$];
    reply_t      awaited_replies[$];
    logic [31:0] value_pool[8];

    int tx_idle_pct   = 0;
    int rx_stall_pct  = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int cycle_count   = 0;
    int mismatch_count = 0;
    int words_sent    = 0;
    int words_checked = 0;
    int full_reached  = 0;
    int empty_reached = 0;

    cursor_linked_list_engine_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),   // position[6:0], value[38:7], zero pad
        .s_tuser  (s_tuser),   // req_type[2:0]
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)    // status[1:0], data_out[33:2], found_position[40:34],
                               // count[47:41], is_full[48], is_empty[49], zero pad
    );

    always #4 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    // positional list behavior applied to the bench copy of the list
    function automatic reply_t apply_request(logic [REQ_W-1:0] req, logic [6:0] pos,
                                             logic [31:0] val);
        reply_t r;
        int     n;
        n = list_words.size();
        r.status = STAT_INFEASIBLE;
        r.data_out = '0;
        r.found_position = '0;
        case (req)
            REQ_INSERT: begin
                if (pos < 1 || pos > CAPACITY) begin
                    r.status = STAT_INFEASIBLE;
                end else if (n >= CAPACITY || pos > n + 1) begin
                    r.status = STAT_ERROR;
                end else begin
                    list_words.insert(pos - 1, val);
                    r.status = STAT_OK;
                end
            end
            REQ_APPEND: begin
                if (n >= CAPACITY) begin
                    r.status = STAT_ERROR;
                end else begin
                    list_words.push_back(val);
                    r.status = STAT_OK;
                end
            end
            REQ_REMOVE: begin
                if (n == 0) begin
                    r.status = STAT_INFEASIBLE;
                end else if (pos < 1 || pos > n) begin
                    r.status = STAT_ERROR;
                end else begin
                    r.data_out = list_words[pos - 1];
                    list_words.delete(pos - 1);
                    r.status = STAT_OK;
                end
            end
            REQ_REPLACE, REQ_RETRIEVE: begin
                if (pos < 1 || pos > n) begin
                    r.status = STAT_ERROR;
                end else if (req == REQ_REPLACE) begin
                    list_words[pos - 1] = val;
                    r.status = STAT_OK;
                end else begin
                    r.data_out = list_words[pos - 1];
                    r.status = STAT_OK;
                end
            end
            REQ_SEARCH: begin
                r.status = STAT_ERROR;
                for (int i = 0; i < n; i++) begin
                    if (list_words[i] == val) begin
                        r.found_position = 7'(i + 1);
                        r.status = STAT_OK;
                        break;
                    end
                end
            end
            default: r.status = STAT_INFEASIBLE;
        endcase
        r.count = 7'(list_words.size());
        r.is_full = (list_words.size() == CAPACITY);
        r.is_empty = (list_words.size() == 0);
        return r;
    endfunction

    task automatic send_request(logic [REQ_W-1:0] req, logic [6:0] pos, logic [31:0] val);
        reply_t r;
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= req;
        s_tdata <= {1'b0, val, pos};
        do @(posedge aclk); while (!s_tready);
        r = apply_request(req, pos, val);
        awaited_replies.push_back(r);
        words_sent++;
        if (r.is_full && (req == REQ_INSERT || req == REQ_APPEND) && r.status == STAT_OK)
            full_reached++;
        if (r.is_empty && req == REQ_REMOVE && r.status == STAT_OK)
            empty_reached++;
        @(negedge aclk);
    endtask

    // result checker
    always @(posedge aclk) begin
        reply_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_replies.size() == 0) begin
                $error("result word with no request waiting: %h", m_tdata);
                mismatch_count++;
            end else begin
                exp_r = awaited_replies.pop_front();
                words_checked++;
                if (m_tdata[1:0] !== exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_tdata[1:0]);
                    mismatch_count++;
                end
                if (m_tdata[33:2] !== exp_r.data_out) begin
                    $error("data_out: expected %h, got %h", exp_r.data_out, m_tdata[33:2]);
                    mismatch_count++;
                end
                if (m_tdata[40:34] !== exp_r.found_position) begin
                    $error("found_position: expected %0d, got %0d",
                           exp_r.found_position, m_tdata[40:34]);
                    mismatch_count++;
                end
                if (m_tdata[47:41] !== exp_r.count) begin
                    $error("count: expected %0d, got %0d", exp_r.count, m_tdata[47:41]);
                    mismatch_count++;
                end
                if (m_tdata[48] !== exp_r.is_full) begin
                    $error("is_full: expected %0d, got %0d", exp_r.is_full, m_tdata[48]);
                    mismatch_count++;
                end
                if (m_tdata[49] !== exp_r.is_empty) begin
                    $error("is_empty: expected %0d, got %0d", exp_r.is_empty, m_tdata[49]);
                    mismatch_count++;
                end
            end
        end
    end

    // result ready pacing, with an occasional long hold-off
    always @(negedge aclk) begin
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(99);
        if (r < 30) return value_pool[$urandom_range(7)];
        if (r < 35) return 32'h0;
        if (r < 40) return 32'hFFFF_FFFF;
        return $urandom;
    endfunction

    function automatic logic [6:0] pick_position(logic [REQ_W-1:0] req);
        int n;
        int top;
        int r;
        n = list_words.size();
        top = (req == REQ_INSERT) ? n + 1 : n;
        r = $urandom_range(99);
        if (r < 80) return 7'($urandom_range((top < 1) ? 1 : top, 1));
        if (r < 90) begin
            case ($urandom_range(4))
                0: return 7'd0;
                1: return 7'(top);
                2: return 7'(top + 1);
                3: return 7'(CAPACITY);
                default: return 7'(CAPACITY + 1);
            endcase
        end
        return 7'($urandom_range(MAX_POSITION));
    endfunction

    task automatic run_mix(mix_t mix, int n_items);
        int               r;
        int               idx;
        logic [REQ_W-1:0] req;
        logic [31:0]      val;
        for (int k = 0; k < n_items; k++) begin
            r = $urandom_range(99);
            if (r < 3) begin
                req = 3'($urandom_range(REQ_UNUSED_HI, REQ_UNUSED_LO));
            end else begin
                case (mix)
                    FILL_HEAVY: idx = (r < 45) ? 0 : (r < 75) ? 1 : (r < 80) ? 2 :
                                      (r < 87) ? 3 : (r < 94) ? 4 : 5;
                    DRAIN_HEAVY: idx = (r < 13) ? 0 : (r < 18) ? 1 : (r < 70) ? 2 :
                                       (r < 80) ? 3 : (r < 90) ? 4 : 5;
                    default: idx = (r < 25) ? 0 : (r < 40) ? 1 : (r < 62) ? 2 :
                                   (r < 74) ? 3 : (r < 87) ? 4 : 5;
                endcase
                case (idx)
                    0: req = REQ_INSERT;
                    1: req = REQ_APPEND;
                    2: req = REQ_REMOVE;
                    3: req = REQ_REPLACE;
                    4: req = REQ_RETRIEVE;
                    default: req = REQ_SEARCH;
                endcase
            end
            if (req == REQ_SEARCH && list_words.size() > 0 && $urandom_range(99) < 60)
                val = list_words[$urandom_range(list_words.size() - 1)];
            else
                val = pick_value();
            send_request(req, pick_position(req), val);
        end
    endtask

    task automatic test_empty_list();
        send_request(REQ_REMOVE, 7'd1, 32'h0);
        send_request(REQ_RETRIEVE, 7'd1, 32'h0);
        send_request(REQ_REPLACE, 7'd0, 32'h1234_5678);
        send_request(REQ_SEARCH, 7'd0, 32'h0);
        send_request(REQ_UNUSED_LO, 7'd1, 32'hFFFF_FFFF);
        send_request(REQ_UNUSED_HI, 7'd127, 32'h0);
        send_request(REQ_INSERT, 7'd0, 32'h1);
        send_request(REQ_INSERT, 7'(CAPACITY + 1), 32'h1);
        send_request(REQ_INSERT, 7'd127, 32'h1);
        send_request(REQ_INSERT, 7'd2, 32'h1);
    endtask

    task automatic test_positional_ops();
        send_request(REQ_INSERT, 7'd1, 32'h0);
        send_request(REQ_APPEND, 7'd127, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 7'd2, 32'hA5A5_5A5A);
        send_request(REQ_INSERT, 7'd5, 32'h1);
        send_request(REQ_APPEND, 7'd0, 32'hA5A5_5A5A);
        send_request(REQ_REPLACE, 7'd3, 32'h8000_0001);
        send_request(REQ_RETRIEVE, 7'd1, 32'h0);
        send_request(REQ_RETRIEVE, 7'd3, 32'h0);
        send_request(REQ_RETRIEVE, 7'd5, 32'h0);
        send_request(REQ_SEARCH, 7'd0, 32'hA5A5_5A5A);
        send_request(REQ_SEARCH, 7'd0, 32'h7777_7777);
        send_request(REQ_REMOVE, 7'd0, 32'h0);
        send_request(REQ_REMOVE, 7'd4, 32'h0);
        send_request(REQ_REMOVE, 7'd1, 32'h0);
        send_request(REQ_REMOVE, 7'd4, 32'h0);
    endtask

    task automatic test_result_stall();
        hold_requests++;
        run_mix(FILL_HEAVY, 40);
    endtask

    task automatic test_random_traffic(int tx_pct, int rx_pct);
        tx_idle_pct = tx_pct;
        rx_stall_pct = rx_pct;
        run_mix(FILL_HEAVY, 85);
        run_mix(DRAIN_HEAVY, 85);
        run_mix(BALANCED, 60);
    endtask

    initial begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        value_pool[0] = 32'h0;
        value_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < 8; i++) value_pool[i] = $urandom;
        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        test_empty_list();
        test_positional_ops();
        test_result_stall();
        test_random_traffic(0, 0);
        test_random_traffic(48, 0);
        test_random_traffic(0, 48);
        test_random_traffic(38, 38);

        s_tvalid <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d requests and %0d results; list filled %0d times, drained %0d times",
                 words_sent, words_checked, full_reached, empty_reached);
        $display("pacing: free flow, request gaps, result stalls, both, and one long hold-off");
        if (mismatch_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

`default_nettype wire
